// File: hw/rtl/pdpc_pkg.sv
package pdpc_pkg;

	localparam int POSITION_BITS      = 21;
	localparam int GAIN_FRACTION_BITS = 8;

	localparam int GAIN_BITS      = 12;
	localparam int MAX_DRIVE_BITS = 8;
	localparam int THRESH_BITS    = 10;
	localparam int WEIGHT_BITS    = 9;
	localparam int DRIVE_BITS     = 9;

	localparam int ERR_BITS    = POSITION_BITS + 1;
	localparam int DIFF_BITS   = POSITION_BITS + 2;
	localparam int PTERM_BITS  = ERR_BITS + GAIN_BITS + 1;
	localparam int DTERM_BITS  = DIFF_BITS + GAIN_BITS + 1;
	localparam int RAW_BITS    = DTERM_BITS + 1;
	localparam int SCALE_NUM   = 154;
	localparam int SCALE_BITS  = 9;
	localparam int SCALED_BITS = RAW_BITS + SCALE_BITS;
	localparam int DIV_SHIFT   = 8 + GAIN_FRACTION_BITS;
	localparam int QUOT_BITS   = SCALED_BITS - DIV_SHIFT;

	localparam int WEIGHT_ONE   = 256;
	localparam int WEIGHT_SHIFT = 8;
	localparam int MIX_BITS     = WEIGHT_BITS + 1 + DRIVE_BITS;
	localparam int SUM_BITS     = MIX_BITS + 1;

	localparam int RUN_STEPS = 6;
	localparam int STEP_BITS = $clog2(RUN_STEPS + 1);

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;
	localparam int IN_DATA_BITS   = ((2 * POSITION_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS  = ((2 * DRIVE_BITS + 1 + 7) / 8) * 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TARGET    = 3'd0,
		REG_MAX_DRIVE = 3'd1,
		REG_KP        = 3'd2,
		REG_KD        = 3'd3,
		REG_THRESH    = 3'd4,
		REG_WEIGHT    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [POSITION_BITS-1:0] target;
		logic [MAX_DRIVE_BITS-1:0]       max_drive;
		logic [GAIN_BITS-1:0]            kp;
		logic [GAIN_BITS-1:0]            kd;
		logic [THRESH_BITS-1:0]          thresh;
		logic [WEIGHT_BITS-1:0]          weight;
	} lane_cfg_t;

	typedef struct packed {
		logic start;
		logic load;
		logic go;
		logic fin;
	} lane_ctl_t;

	typedef struct packed {
		logic                         settled;
		logic signed [DRIVE_BITS-1:0] next_drive;
	} lane_res_t;

endpackage

// File: hw/rtl/pdpc_lane.sv
module pdpc_lane (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pdpc_pkg::lane_cfg_t                      cfg,
	input  pdpc_pkg::lane_ctl_t                      ctl,
	input  logic signed [pdpc_pkg::POSITION_BITS-1:0] pos,
	output pdpc_pkg::lane_res_t                      res
);

	logic signed [pdpc_pkg::ERR_BITS-1:0]    last_q;
	logic signed [pdpc_pkg::DRIVE_BITS-1:0]  smooth_q;

	logic signed [pdpc_pkg::ERR_BITS-1:0]    target_ext;
	logic signed [pdpc_pkg::ERR_BITS-1:0]    last_eff;
	logic signed [pdpc_pkg::ERR_BITS-1:0]    err_c;
	logic signed [pdpc_pkg::DIFF_BITS-1:0]   diff_c;
	logic signed [pdpc_pkg::ERR_BITS-1:0]    thr_s;
	logic                                    settled_c;
	logic signed [pdpc_pkg::DRIVE_BITS-1:0]  drive_c;

	logic signed [pdpc_pkg::ERR_BITS-1:0]    err_s1;
	logic signed [pdpc_pkg::DIFF_BITS-1:0]   diff_s1;
	logic signed [pdpc_pkg::PTERM_BITS-1:0]  pterm_s2;
	logic signed [pdpc_pkg::DTERM_BITS-1:0]  dterm_s2;
	logic signed [pdpc_pkg::RAW_BITS-1:0]    raw_s3;
	logic signed [pdpc_pkg::SCALED_BITS-1:0] scaled_s4;
	logic signed [pdpc_pkg::SCALED_BITS-1:0] scaled_rnd;
	logic signed [pdpc_pkg::QUOT_BITS-1:0]   quot;
	logic signed [pdpc_pkg::QUOT_BITS-1:0]   lim;
	logic signed [pdpc_pkg::DRIVE_BITS-1:0]  cmd_c;
	logic signed [pdpc_pkg::DRIVE_BITS-1:0]  cmd_s5;
	logic signed [pdpc_pkg::MIX_BITS-1:0]    hold_s6;
	logic signed [pdpc_pkg::MIX_BITS-1:0]    push_s6;
	logic signed [pdpc_pkg::SUM_BITS-1:0]    mix_sum;
	logic signed [pdpc_pkg::SUM_BITS-1:0]    mix_rnd;
	logic [pdpc_pkg::WEIGHT_BITS-1:0]        w_rest;

	always_comb begin
		target_ext = {cfg.target[pdpc_pkg::POSITION_BITS-1], cfg.target};
		last_eff   = ctl.start ? target_ext : last_q;
		err_c      = target_ext - {pos[pdpc_pkg::POSITION_BITS-1], pos};
		diff_c     = {err_c[pdpc_pkg::ERR_BITS-1], err_c}
		           - {last_eff[pdpc_pkg::ERR_BITS-1], last_eff};
		thr_s      = $signed({{(pdpc_pkg::ERR_BITS-pdpc_pkg::THRESH_BITS){1'b0}}, cfg.thresh});
		settled_c  = (last_eff <= thr_s) && (last_eff >= -thr_s);
	end

	// divide by 2^16 rounding toward zero, then clamp
	always_comb begin
		scaled_rnd = scaled_s4;
		if (scaled_s4 < 0) begin
			scaled_rnd = scaled_s4 + $signed({{(pdpc_pkg::SCALED_BITS-pdpc_pkg::DIV_SHIFT){1'b0}},
				{pdpc_pkg::DIV_SHIFT{1'b1}}});
		end
		quot = scaled_rnd[pdpc_pkg::SCALED_BITS-1:pdpc_pkg::DIV_SHIFT];
		lim  = $signed({{(pdpc_pkg::QUOT_BITS-pdpc_pkg::MAX_DRIVE_BITS){1'b0}}, cfg.max_drive});
		if (quot > lim) begin
			cmd_c = lim[pdpc_pkg::DRIVE_BITS-1:0];
		end else if (quot < -lim) begin
			cmd_c = -$signed(lim[pdpc_pkg::DRIVE_BITS-1:0]);
		end else begin
			cmd_c = quot[pdpc_pkg::DRIVE_BITS-1:0];
		end
		w_rest = pdpc_pkg::WEIGHT_BITS'(pdpc_pkg::WEIGHT_ONE) - cfg.weight;
	end

	always_comb begin
		mix_sum = {hold_s6[pdpc_pkg::MIX_BITS-1], hold_s6}
		        + {push_s6[pdpc_pkg::MIX_BITS-1], push_s6};
		mix_rnd = mix_sum;
		if (mix_sum < 0) begin
			mix_rnd = mix_sum + $signed({{(pdpc_pkg::SUM_BITS-pdpc_pkg::WEIGHT_SHIFT){1'b0}},
				{pdpc_pkg::WEIGHT_SHIFT{1'b1}}});
		end
		drive_c = mix_rnd[pdpc_pkg::WEIGHT_SHIFT+pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::WEIGHT_SHIFT];
	end

	assign res = '{settled: settled_c, next_drive: drive_c};

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			err_s1  <= err_c;
			diff_s1 <= diff_c;
		end
		pterm_s2  <= pdpc_pkg::PTERM_BITS'($signed({1'b0, cfg.kp}))
			* pdpc_pkg::PTERM_BITS'(err_s1);
		dterm_s2  <= pdpc_pkg::DTERM_BITS'($signed({1'b0, cfg.kd}))
			* pdpc_pkg::DTERM_BITS'(diff_s1);
		raw_s3    <= {{(pdpc_pkg::RAW_BITS-pdpc_pkg::PTERM_BITS){pterm_s2[pdpc_pkg::PTERM_BITS-1]}},
			pterm_s2} + {dterm_s2[pdpc_pkg::DTERM_BITS-1], dterm_s2};
		scaled_s4 <= pdpc_pkg::SCALED_BITS'(raw_s3)
			* pdpc_pkg::SCALED_BITS'(pdpc_pkg::SCALE_NUM);
		cmd_s5    <= cmd_c;
		hold_s6   <= pdpc_pkg::MIX_BITS'($signed({1'b0, cfg.weight}))
			* pdpc_pkg::MIX_BITS'(smooth_q);
		push_s6   <= pdpc_pkg::MIX_BITS'($signed({1'b0, w_rest}))
			* pdpc_pkg::MIX_BITS'(cmd_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			smooth_q <= '0;
		end else if (ctl.load) begin
			last_q <= target_ext;
		end else if (ctl.fin) begin
			last_q   <= err_s1;
			smooth_q <= drive_c;
		end
	end

endmodule

// File: hw/rtl/dual_side_pd_position_controller.sv
// output: an idle or settling tick gives its result in the cycle after the transfer;
// a driving tick gives it through the per-side pd/smoothing pipe
// (err, two gain products, sum, scale product, clamp, ema products, ema sum);
// ticks are taken one at a time, a new one only once the last has left the pipe
// reset: async active low; registers to defaults, errors and drives zero, no move active
module dual_side_pd_position_controller (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// left_position, right_position
	input  logic [pdpc_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	// start_move
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// left_drive, right_drive, move_done, zero fill
	output logic [pdpc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pdpc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [pdpc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int PB = pdpc_pkg::POSITION_BITS;
	localparam int DB = pdpc_pkg::DRIVE_BITS;

	logic signed [PB-1:0]                   target_q;
	logic [pdpc_pkg::MAX_DRIVE_BITS-1:0]    max_drive_q;
	logic [pdpc_pkg::GAIN_BITS-1:0]         kp_q;
	logic [pdpc_pkg::GAIN_BITS-1:0]         kd_q;
	logic [pdpc_pkg::THRESH_BITS-1:0]       thresh_q;
	logic [pdpc_pkg::WEIGHT_BITS-1:0]       weight_q;

	logic                                   active_q;
	logic [pdpc_pkg::STEP_BITS-1:0]         step_q;
	logic                                   out_valid_q;
	logic signed [DB-1:0]                   left_out_q;
	logic signed [DB-1:0]                   right_out_q;
	logic                                   done_out_q;

	pdpc_pkg::lane_cfg_t                    lane_cfg;
	pdpc_pkg::lane_ctl_t                    lane_ctl;
	pdpc_pkg::lane_res_t                    left_res;
	pdpc_pkg::lane_res_t                    right_res;

	logic accept;
	logic run;
	logic slot_free;
	logic last_step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			max_drive_q <= pdpc_pkg::MAX_DRIVE_BITS'(160);
			kp_q        <= pdpc_pkg::GAIN_BITS'(205);
			kd_q        <= pdpc_pkg::GAIN_BITS'(256);
			thresh_q    <= pdpc_pkg::THRESH_BITS'(20);
			weight_q    <= pdpc_pkg::WEIGHT_BITS'(248);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pdpc_pkg::REG_TARGET:    target_q    <= cfg_data[PB-1:0];
				pdpc_pkg::REG_MAX_DRIVE: max_drive_q <= cfg_data[pdpc_pkg::MAX_DRIVE_BITS-1:0];
				pdpc_pkg::REG_KP:        kp_q        <= cfg_data[pdpc_pkg::GAIN_BITS-1:0];
				pdpc_pkg::REG_KD:        kd_q        <= cfg_data[pdpc_pkg::GAIN_BITS-1:0];
				pdpc_pkg::REG_THRESH:    thresh_q    <= cfg_data[pdpc_pkg::THRESH_BITS-1:0];
				pdpc_pkg::REG_WEIGHT:    weight_q    <= cfg_data[pdpc_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lane_cfg.target    = target_q;
		lane_cfg.max_drive = max_drive_q;
		lane_cfg.kp        = kp_q;
		lane_cfg.kd        = kd_q;
		lane_cfg.thresh    = thresh_q;
		lane_cfg.weight    = (weight_q > pdpc_pkg::WEIGHT_BITS'(pdpc_pkg::WEIGHT_ONE))
		                   ? pdpc_pkg::WEIGHT_BITS'(pdpc_pkg::WEIGHT_ONE) : weight_q;
	end

	always_comb begin
		slot_free     = !out_valid_q || m_axis_tready;
		s_axis_tready = (step_q == '0) && slot_free;
		accept        = s_axis_tvalid && s_axis_tready;
		run           = (s_axis_tuser || active_q) && !(left_res.settled && right_res.settled);
		last_step     = (step_q == pdpc_pkg::STEP_BITS'(pdpc_pkg::RUN_STEPS));
		lane_ctl.start = s_axis_tuser;
		lane_ctl.load  = accept && s_axis_tuser;
		lane_ctl.go    = accept && run;
		lane_ctl.fin   = last_step && slot_free;
	end

	pdpc_lane u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (lane_cfg),
		.ctl    (lane_ctl),
		.pos    (s_axis_tdata[PB-1:0]),
		.res    (left_res)
	);

	pdpc_lane u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (lane_cfg),
		.ctl    (lane_ctl),
		.pos    (s_axis_tdata[2*PB-1:PB]),
		.res    (right_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				active_q <= run;
			end
			if (lane_ctl.go) begin
				step_q <= pdpc_pkg::STEP_BITS'(1);
			end else if (lane_ctl.fin) begin
				step_q <= '0;
			end else if (step_q != '0 && !last_step) begin
				step_q <= step_q + pdpc_pkg::STEP_BITS'(1);
			end
			if ((accept && !run) || lane_ctl.fin) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// merge the two sides into one result transfer
	always_ff @(posedge clk) begin
		if (accept && !run) begin
			left_out_q  <= '0;
			right_out_q <= '0;
			done_out_q  <= 1'b1;
		end else if (lane_ctl.fin) begin
			left_out_q  <= left_res.next_drive;
			right_out_q <= right_res.next_drive;
			done_out_q  <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(pdpc_pkg::OUT_DATA_BITS-2*DB-1){1'b0}},
		done_out_q, right_out_q, left_out_q};

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= pdpc_pkg::STEP_BITS'(pdpc_pkg::RUN_STEPS))
		else $error("step counter out of range");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2*DB]) |-> (m_axis_tdata[2*DB-1:0] == '0))
		else $error("drive not zero on a done result");

	a_drive_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[2*DB]) |-> active_q)
		else $error("drive result without an active move");

	a_fin_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		lane_ctl.go |=> (step_q == pdpc_pkg::STEP_BITS'(1)) && !out_valid_q)
		else $error("pipeline did not start after a driving tick");
`endif

endmodule

// File: verif/tb_dual_side_pd_position_controller.sv
module tb_dual_side_pd_position_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pdpc_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [pdpc_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
	localparam longint POS_MIN = -(longint'(1) << (pdpc_pkg::POSITION_BITS - 1));
	localparam longint POS_MAX = (longint'(1) << (pdpc_pkg::POSITION_BITS - 1)) - 1;
	localparam int RANDOM_TICKS = 1200;
	localparam int CYCLE_LIMIT = 400000;

	class drive_ledger;
		longint target;
		longint max_drive;
		longint kp;
		longint kd;
		longint thresh;
		longint weight;
		longint left_err;
		longint right_err;
		longint left_drv;
		longint right_drv;
		bit active;
		int errors;
		logic [pdpc_pkg::OUT_DATA_BITS-1:0] expected_drives[$];

		function new();
			target = 0;
			max_drive = 160;
			kp = 205;
			kd = 256;
			thresh = 20;
			weight = 248;
			left_err = 0;
			right_err = 0;
			left_drv = 0;
			right_drv = 0;
			active = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [pdpc_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [pdpc_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
				pdpc_pkg::REG_TARGET: target = $signed(data[pdpc_pkg::POSITION_BITS-1:0]);
				pdpc_pkg::REG_MAX_DRIVE: max_drive = data[pdpc_pkg::MAX_DRIVE_BITS-1:0];
				pdpc_pkg::REG_KP: kp = data[pdpc_pkg::GAIN_BITS-1:0];
				pdpc_pkg::REG_KD: kd = data[pdpc_pkg::GAIN_BITS-1:0];
				pdpc_pkg::REG_THRESH: thresh = data[pdpc_pkg::THRESH_BITS-1:0];
				pdpc_pkg::REG_WEIGHT: weight = data[pdpc_pkg::WEIGHT_BITS-1:0];
				default: ;
			endcase
		endfunction

		// pd command scaled by 0.6, clamped, then blended into the old drive
		function longint smooth_drive(longint err, longint last, longint old);
			longint raw;
			longint cmd;
			longint w;
			raw = kp * err + kd * (err - last);
			cmd = (raw * pdpc_pkg::SCALE_NUM) / (longint'(1) << pdpc_pkg::DIV_SHIFT);
			if (cmd > max_drive)
				cmd = max_drive;
			if (cmd < -max_drive)
				cmd = -max_drive;
			w = (weight > pdpc_pkg::WEIGHT_ONE) ? longint'(pdpc_pkg::WEIGHT_ONE) : weight;
			return (w * old + (pdpc_pkg::WEIGHT_ONE - w) * cmd) / pdpc_pkg::WEIGHT_ONE;
		endfunction

		function void take_tick(bit start, longint lpos, longint rpos);
			longint lerr;
			longint rerr;
			logic [pdpc_pkg::OUT_DATA_BITS-1:0] word;
			word = '0;
			word[2*pdpc_pkg::DRIVE_BITS] = 1'b1;
			if (start) begin
				active = 1'b1;
				left_err = target;
				right_err = target;
			end
			if (active) begin
				if ((left_err < 0 ? -left_err : left_err) <= thresh &&
						(right_err < 0 ? -right_err : right_err) <= thresh) begin
					active = 1'b0;
				end else begin
					lerr = target - lpos;
					rerr = target - rpos;
					left_drv = smooth_drive(lerr, left_err, left_drv);
					right_drv = smooth_drive(rerr, right_err, right_drv);
					left_err = lerr;
					right_err = rerr;
					word[pdpc_pkg::DRIVE_BITS-1:0] = left_drv[pdpc_pkg::DRIVE_BITS-1:0];
					word[2*pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::DRIVE_BITS] =
						right_drv[pdpc_pkg::DRIVE_BITS-1:0];
					word[2*pdpc_pkg::DRIVE_BITS] = 1'b0;
				end
			end
			expected_drives = {expected_drives, word};
		endfunction

		function void check_drive(logic [pdpc_pkg::OUT_DATA_BITS-1:0] got);
			logic [pdpc_pkg::OUT_DATA_BITS-1:0] want;
			if (expected_drives.size() == 0) begin
				$display("%0t: drive transfer with none pending, expected nothing actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_drives.pop_front();
			if (got[pdpc_pkg::DRIVE_BITS-1:0] !== want[pdpc_pkg::DRIVE_BITS-1:0]) begin
				$display("%0t: left_drive expected %0d actual %0d", $time,
					$signed(want[pdpc_pkg::DRIVE_BITS-1:0]),
					$signed(got[pdpc_pkg::DRIVE_BITS-1:0]));
				errors++;
			end
			if (got[2*pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::DRIVE_BITS] !==
					want[2*pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::DRIVE_BITS]) begin
				$display("%0t: right_drive expected %0d actual %0d", $time,
					$signed(want[2*pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::DRIVE_BITS]),
					$signed(got[2*pdpc_pkg::DRIVE_BITS-1:pdpc_pkg::DRIVE_BITS]));
				errors++;
			end
			if (got[2*pdpc_pkg::DRIVE_BITS] !== want[2*pdpc_pkg::DRIVE_BITS]) begin
				$display("%0t: move_done expected %0b actual %0b", $time,
					want[2*pdpc_pkg::DRIVE_BITS], got[2*pdpc_pkg::DRIVE_BITS]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [pdpc_pkg::IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [pdpc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pdpc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [pdpc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	drive_ledger drives = new();
	logic [pdpc_pkg::CFG_INDEX_BITS-1:0] pend_idx[$];
	logic [pdpc_pkg::CFG_DATA_BITS-1:0] pend_data[$];
	int ticks_sent = 0;
	int tx_idle_pct = 20;
	int rx_stall_pct = 20;
	int rx_stall = 0;
	bit calm = 1'b0;
	int cycles = 0;

	dual_side_pd_position_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			drives.check_drive(m_axis_tdata);
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(99) < rx_stall_pct) begin
			rx_stall <= $urandom_range(8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic longint rand_pos();
		logic signed [pdpc_pkg::POSITION_BITS-1:0] v;
		v = pdpc_pkg::POSITION_BITS'($urandom);
		return v;
	endfunction

	function automatic longint clip_pos(longint p);
		if (p > POS_MAX)
			return POS_MAX;
		if (p < POS_MIN)
			return POS_MIN;
		return p;
	endfunction

	// wheel creeps toward the target with some jitter
	function automatic longint advance(longint p);
		longint step;
		step = (drives.target - p) * longint'($urandom_range(1, 6)) / 8;
		return clip_pos(p + step + longint'($urandom_range(16)) - 8);
	endfunction

	function automatic logic [pdpc_pkg::CFG_DATA_BITS-1:0] pick_field(int bits);
		case ($urandom_range(7))
			0: return '0;
			1: return pdpc_pkg::CFG_DATA_BITS'((1 << bits) - 1);
			2: return pdpc_pkg::CFG_DATA_BITS'($urandom);
			default: return pdpc_pkg::CFG_DATA_BITS'($urandom_range((1 << bits) - 1));
		endcase
	endfunction

	function automatic longint pick_target();
		case ($urandom_range(9))
			0: return POS_MIN;
			1: return POS_MAX;
			2, 3: return rand_pos();
			default: return longint'($urandom_range(16000)) - 8000;
		endcase
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	function automatic void stage_reg(logic [pdpc_pkg::CFG_INDEX_BITS-1:0] idx, longint data);
		pend_idx = {pend_idx, idx};
		pend_data = {pend_data, data[pdpc_pkg::CFG_DATA_BITS-1:0]};
	endfunction

	task automatic send_tick(input bit start, input longint lpos, input longint rpos);
		logic [pdpc_pkg::POSITION_BITS-1:0] lbits;
		logic [pdpc_pkg::POSITION_BITS-1:0] rbits;
		lbits = lpos[pdpc_pkg::POSITION_BITS-1:0];
		rbits = rpos[pdpc_pkg::POSITION_BITS-1:0];
		if (!calm && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= start;
		s_axis_tdata <= {{(pdpc_pkg::IN_DATA_BITS - 2*pdpc_pkg::POSITION_BITS){1'b0}},
			rbits, lbits};
		do @(posedge clk); while (!s_axis_tready);
		drives.take_tick(start, lpos, rpos);
		ticks_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (drives.expected_drives.size() != 0);
	endtask

	task automatic load_settings();
		wait_drained();
		while (pend_idx.size() != 0) begin
			cfg_valid <= 1'b1;
			cfg_index <= pend_idx[0];
			cfg_data <= pend_data[0];
			do @(posedge clk); while (!cfg_ready);
			drives.write_reg(pend_idx.pop_front(), pend_data.pop_front());
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_settings();
		tx_idle_pct = pick_pct();
		rx_stall_pct = pick_pct();
		if ($urandom_range(99) < 70)
			stage_reg(pdpc_pkg::REG_TARGET, pick_target());
		if ($urandom_range(99) < 50)
			stage_reg(pdpc_pkg::REG_MAX_DRIVE, pick_field(pdpc_pkg::MAX_DRIVE_BITS));
		if ($urandom_range(99) < 50)
			stage_reg(pdpc_pkg::REG_KP, pick_field(pdpc_pkg::GAIN_BITS));
		if ($urandom_range(99) < 50)
			stage_reg(pdpc_pkg::REG_KD, pick_field(pdpc_pkg::GAIN_BITS));
		if ($urandom_range(99) < 50)
			stage_reg(pdpc_pkg::REG_THRESH, pick_field(pdpc_pkg::THRESH_BITS));
		if ($urandom_range(99) < 50)
			stage_reg(pdpc_pkg::REG_WEIGHT, pick_field(pdpc_pkg::WEIGHT_BITS));
		if ($urandom_range(99) < 10)
			stage_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
		load_settings();
	endtask

	task automatic run_moves();
		int steps;
		longint lp;
		longint rp;
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(9) == 0) begin
				// noise ticks, start bit and positions at random
				repeat ($urandom_range(1, 6))
					send_tick($urandom_range(1), rand_pos(), rand_pos());
			end else begin
				lp = longint'($urandom_range(100)) - 50;
				rp = longint'($urandom_range(100)) - 50;
				send_tick(1'b1, lp, rp);
				steps = 0;
				while (drives.active && steps < 60) begin
					lp = advance(lp);
					rp = advance(rp);
					if ($urandom_range(49) == 0)
						send_tick(1'b1, lp, rp);
					else if ($urandom_range(49) == 0)
						send_tick(1'b0, rand_pos(), rand_pos());
					else
						send_tick(1'b0, lp, rp);
					steps++;
				end
				repeat ($urandom_range(3))
					send_tick(1'b0, rand_pos(), rand_pos());
			end
		end
	endtask

	initial begin
		int first_random;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// idle ticks at both position extremes, then a start inside the settle band
		send_tick(1'b0, POS_MIN, POS_MAX);
		send_tick(1'b0, POS_MAX, POS_MIN);
		send_tick(1'b1, 0, 0);
		send_tick(1'b0, 17, -17);

		// largest gains and errors, no smoothing, zero threshold
		stage_reg(pdpc_pkg::REG_TARGET, POS_MAX);
		stage_reg(pdpc_pkg::REG_MAX_DRIVE, 255);
		stage_reg(pdpc_pkg::REG_KP, 4095);
		stage_reg(pdpc_pkg::REG_KD, 4095);
		stage_reg(pdpc_pkg::REG_THRESH, 0);
		stage_reg(pdpc_pkg::REG_WEIGHT, 0);
		load_settings();
		send_tick(1'b1, POS_MIN, POS_MIN);
		send_tick(1'b0, POS_MIN, POS_MAX);
		send_tick(1'b0, POS_MAX, POS_MAX);
		send_tick(1'b0, POS_MAX, POS_MAX);

		// zero clamp with full smoothing weight
		stage_reg(pdpc_pkg::REG_TARGET, POS_MIN);
		stage_reg(pdpc_pkg::REG_MAX_DRIVE, 0);
		stage_reg(pdpc_pkg::REG_WEIGHT, pdpc_pkg::WEIGHT_ONE);
		load_settings();
		send_tick(1'b1, POS_MAX, 0);
		send_tick(1'b0, POS_MAX, POS_MIN);

		// weight above one keeps the old drive
		stage_reg(pdpc_pkg::REG_MAX_DRIVE, 255);
		stage_reg(pdpc_pkg::REG_WEIGHT, 511);
		load_settings();
		send_tick(1'b0, 12345, -12345);

		// restart during a move, then settle and go idle
		stage_reg(pdpc_pkg::REG_TARGET, 3000);
		stage_reg(pdpc_pkg::REG_MAX_DRIVE, 160);
		stage_reg(pdpc_pkg::REG_KP, 205);
		stage_reg(pdpc_pkg::REG_KD, 256);
		stage_reg(pdpc_pkg::REG_THRESH, 1023);
		stage_reg(pdpc_pkg::REG_WEIGHT, 128);
		load_settings();
		send_tick(1'b0, 0, 0);
		send_tick(1'b1, 0, 0);
		send_tick(1'b0, 1500, 1400);
		send_tick(1'b1, 200, -200);
		send_tick(1'b0, 2500, 2600);
		send_tick(1'b0, 2990, 3010);
		send_tick(1'b0, 3000, 3000);
		send_tick(1'b0, 100, -100);

		// unused register indexes are ignored
		stage_reg(REG_SPARE_LO, $urandom);
		stage_reg(REG_SPARE_HI, $urandom);
		stage_reg(pdpc_pkg::REG_TARGET, -1000);
		load_settings();
		send_tick(1'b1, 5, 5);
		send_tick(1'b0, -5, 5);

		first_random = ticks_sent;
		while (ticks_sent - first_random < RANDOM_TICKS) begin
			calm = (ticks_sent - first_random) > (RANDOM_TICKS * 85) / 100;
			pick_settings();
			if (calm) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			run_moves();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (drives.errors == 0 && drives.expected_drives.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pdpc_pkg.sv
hw/rtl/pdpc_lane.sv
hw/rtl/dual_side_pd_position_controller.sv
verif/tb_dual_side_pd_position_controller.sv
